// ===== rtl/sync_length_checksum_packet_deframer_macros.svh =====
// assertion macros shared by the deframer modules
`ifndef SYNC_LENGTH_CHECKSUM_PACKET_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_PACKET_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF
// condition holds on every clock edge out of reset
`define SLCD_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("slcd assertion failed");
// consequent holds in the cycle after the antecedent
`define SLCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slcd assertion failed");
`else
`define SLCD_ASSERT(lbl, cond)
`define SLCD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/slcd_pkg.sv =====
// shared types and constants of the frame deframer
package slcd_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] START_RESET   = 8'h55;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 7'd64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear;        // restart the hunt: held fields, sum and index to zero
        logic add_sum;      // add the input byte to the running sum
        logic load_cmd;     // capture the command byte
        logic load_len;     // capture the length byte
        logic store_data;   // write payload byte at index, step index
        logic idx_clear;    // rewind the index for read-out
        logic rd_issue;     // read payload memory at index
        logic load_beat;    // load a payload result beat, step index
        logic load_single;  // load the single error or empty-payload beat
        logic single_err;   // status of the single beat
    } slcd_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic byte_is_start;
        logic over_limit;
        logic byte_zero;
        logic len_zero;
        logic idx_at_end;
        logic sum_match;
        logic out_free;
    } slcd_sts_t;

endpackage

// ===== rtl/slcd_datapath.sv =====
// deframer datapath: config, header fields, checksum, payload memory, result register
`include "sync_length_checksum_packet_deframer_macros.svh"

module slcd_datapath #(
    parameter int MAX_DATA = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slcd_pkg::BYTE_W-1:0]       cfg_data,
    input  logic [slcd_pkg::BYTE_W-1:0]       rx_byte,
    input  slcd_pkg::slcd_cmd_t               cmd,
    output slcd_pkg::slcd_sts_t               sts,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              status,
    output logic [slcd_pkg::BYTE_W-1:0]       command,
    output logic [slcd_pkg::LEN_W-1:0]        length,
    output logic [slcd_pkg::BYTE_W-1:0]       data_byte,
    output logic                              data_valid,
    output logic                              last
);
    import slcd_pkg::*;

    localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int CW = (AW + 1 > BYTE_W) ? AW + 1 : BYTE_W;
    localparam logic [BYTE_W-1:0] MAX_DATA_B = BYTE_W'(MAX_DATA);

    logic [BYTE_W-1:0] start_byte_reg;
    logic [LEN_W-1:0]  max_length_reg;
    logic [BYTE_W-1:0] held_command_reg, held_command_next;
    logic [LEN_W-1:0]  held_length_reg, held_length_next;
    logic [BYTE_W-1:0] running_sum_reg, running_sum_next;
    logic [AW-1:0]     idx_reg, idx_next;

    logic [BYTE_W-1:0] payload_mem [MAX_DATA];
    logic [BYTE_W-1:0] rd_data_reg;

    logic              out_valid_reg, out_valid_next;
    logic              out_status_reg;
    logic [BYTE_W-1:0] out_command_reg;
    logic [LEN_W-1:0]  out_length_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_data_valid_reg;
    logic              out_last_reg;

    logic [BYTE_W-1:0] limit;
    logic [CW-1:0]     idx_plus_one;

    // effective limit is the smaller of max_length and the store depth
    always_comb
    begin
        limit = ({1'b0, max_length_reg} > MAX_DATA_B) ? MAX_DATA_B : {1'b0, max_length_reg};
        idx_plus_one = CW'(idx_reg) + CW'(1);
    end

    always_comb
    begin
        sts.byte_is_start = (rx_byte == start_byte_reg);
        sts.over_limit    = (rx_byte > limit);
        sts.byte_zero     = (rx_byte == '0);
        sts.len_zero      = (held_length_reg == '0);
        sts.idx_at_end    = (idx_plus_one == CW'(held_length_reg));
        sts.sum_match     = (rx_byte == running_sum_reg);
        sts.out_free      = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        held_command_next = held_command_reg;
        held_length_next  = held_length_reg;
        running_sum_next  = running_sum_reg;
        idx_next          = idx_reg;
        if (cmd.add_sum)
        begin
            running_sum_next = running_sum_reg + rx_byte;
        end
        if (cmd.load_cmd)
        begin
            held_command_next = rx_byte;
        end
        if (cmd.load_len)
        begin
            held_length_next = rx_byte[LEN_W-1:0];
        end
        if (cmd.store_data || cmd.load_beat)
        begin
            idx_next = idx_reg + AW'(1);
        end
        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        if (cmd.clear)
        begin
            held_command_next = '0;
            held_length_next  = '0;
            running_sum_next  = '0;
            idx_next          = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_beat || cmd.load_single)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg   <= START_RESET;
            max_length_reg   <= MAX_LEN_RESET;
            held_command_reg <= '0;
            held_length_reg  <= '0;
            running_sum_reg  <= '0;
            idx_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_START_BYTE)
            begin
                start_byte_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == CFG_MAX_LENGTH)
            begin
                max_length_reg <= cfg_data[LEN_W-1:0];
            end
            held_command_reg <= held_command_next;
            held_length_reg  <= held_length_next;
            running_sum_reg  <= running_sum_next;
            idx_reg          <= idx_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store_data)
        begin
            payload_mem[idx_reg] <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= payload_mem[idx_reg];
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_beat)
        begin
            out_status_reg     <= 1'b0;
            out_command_reg    <= held_command_reg;
            out_length_reg     <= held_length_reg;
            out_data_reg       <= rd_data_reg;
            out_data_valid_reg <= 1'b1;
            out_last_reg       <= sts.idx_at_end;
        end
        else if (cmd.load_single)
        begin
            out_status_reg     <= cmd.single_err;
            out_command_reg    <= held_command_reg;
            out_length_reg     <= held_length_reg;
            out_data_reg       <= '0;
            out_data_valid_reg <= 1'b0;
            out_last_reg       <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign command    = out_command_reg;
    assign length     = out_length_reg;
    assign data_byte  = out_data_reg;
    assign data_valid = out_data_valid_reg;
    assign last       = out_last_reg;

    // a new beat never overwrites one still waiting
    `SLCD_ASSERT(a_no_overwrite, !(cmd.load_beat || cmd.load_single) || sts.out_free)
    // payload writes stay inside the announced length
    `SLCD_ASSERT(a_store_in_len, !cmd.store_data || (CW'(idx_reg) < CW'(held_length_reg)))
    // a payload beat shows up as a valid data beat
    `SLCD_ASSERT_NEXT(a_beat_loaded, cmd.load_beat, out_valid_reg && out_data_valid_reg)

endmodule

// ===== rtl/slcd_ctrl.sv =====
// deframer controller: frame hunt and result read-out sequencing
module slcd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  slcd_pkg::slcd_sts_t  sts,
    output slcd_pkg::slcd_cmd_t  cmd
);
    import slcd_pkg::*;

    typedef enum logic [3:0] {
        ST_SYNC0,
        ST_SYNC1,
        ST_CMD,
        ST_LEN,
        ST_DATA,
        ST_CHECK,
        ST_SINGLE,
        ST_READ,
        ST_LOAD
    } state_t;

    state_t state_reg, state_next;
    logic   err_reg, err_next;
    logic   in_fire;

    always_comb
    begin
        unique case (state_reg)
            ST_SYNC0, ST_SYNC1, ST_CMD, ST_LEN, ST_DATA, ST_CHECK: in_ready = 1'b1;
            default: in_ready = 1'b0;
        endcase
    end

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        cmd        = '0;
        cmd.single_err = err_reg;
        unique case (state_reg)
            ST_SYNC0:
            begin
                if (in_fire)
                begin
                    if (sts.byte_is_start)
                    begin
                        cmd.add_sum = 1'b1;
                        state_next  = ST_SYNC1;
                    end
                    else
                    begin
                        cmd.clear = 1'b1;
                    end
                end
            end
            ST_SYNC1:
            begin
                if (in_fire)
                begin
                    if (sts.byte_is_start)
                    begin
                        cmd.add_sum = 1'b1;
                        state_next  = ST_CMD;
                    end
                    else
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_SYNC0;
                    end
                end
            end
            ST_CMD:
            begin
                if (in_fire)
                begin
                    if (sts.over_limit)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_SYNC0;
                    end
                    else
                    begin
                        cmd.load_cmd = 1'b1;
                        cmd.add_sum  = 1'b1;
                        state_next   = ST_LEN;
                    end
                end
            end
            ST_LEN:
            begin
                if (in_fire)
                begin
                    if (sts.over_limit)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_SYNC0;
                    end
                    else
                    begin
                        cmd.load_len = 1'b1;
                        cmd.add_sum  = 1'b1;
                        state_next   = sts.byte_zero ? ST_CHECK : ST_DATA;
                    end
                end
            end
            ST_DATA:
            begin
                if (in_fire)
                begin
                    cmd.store_data = 1'b1;
                    cmd.add_sum    = 1'b1;
                    if (sts.idx_at_end)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (in_fire)
                begin
                    cmd.idx_clear = 1'b1;
                    if (!sts.sum_match)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_SINGLE;
                    end
                    else if (sts.len_zero)
                    begin
                        // good frame with empty payload gives one beat
                        err_next   = 1'b0;
                        state_next = ST_SINGLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_single = 1'b1;
                    cmd.clear       = 1'b1;
                    err_next        = 1'b0;
                    state_next      = ST_SYNC0;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_beat = 1'b1;
                    if (sts.idx_at_end)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_SYNC0;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_SYNC0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SYNC0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== rtl/sync_length_checksum_packet_deframer.sv =====
// top level of the sync/length/checksum frame deframer
//
// Hunts a received byte stream for frames [start, start, command, length,
// data..., checksum], where the checksum is the 8-bit sum of all bytes before
// it. While hunting, one byte beat is accepted per cycle. A good frame ends in
// a run of result beats, one per payload byte (or a single beat with
// data_valid low for an empty payload), with last set on the final one; a bad
// checksum gives one beat with status high. Each payload beat is a payload
// memory read followed by a load of the output register. No byte is accepted
// during the drain of the result beats. The output register lets the hunt
// for the next frame start while the last beat still waits for out_ready.
// No clearing pass follows reset: payload bytes are always written before
// they are read. The user must write configuration (start_byte, max_length)
// only while idle; the block itself does not enforce this.
module sync_length_checksum_packet_deframer #(
    parameter int MAX_DATA = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_write,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slcd_pkg::BYTE_W-1:0]       cfg_data,
    // received byte beats
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [slcd_pkg::BYTE_W-1:0]       rx_byte,
    // result beats
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              status,
    output logic [slcd_pkg::BYTE_W-1:0]       command,
    output logic [slcd_pkg::LEN_W-1:0]        length,
    output logic [slcd_pkg::BYTE_W-1:0]       data_byte,
    output logic                              data_valid,
    output logic                              last
);
    import slcd_pkg::*;

    // command and status between the sequencer and the datapath
    slcd_cmd_t cmd;
    slcd_sts_t sts;

    // frame hunt and read-out sequencing
    slcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // header capture, running sum, payload memory and output register
    slcd_datapath #(
        .MAX_DATA (MAX_DATA)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .rx_byte    (rx_byte),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .status     (status),
        .command    (command),
        .length     (length),
        .data_byte  (data_byte),
        .data_valid (data_valid),
        .last       (last)
    );

endmodule
